// ===== design/nsbm_pkg.sv =====
package nsbm_pkg;

  localparam int unsigned ColW   = 8;
  localparam int unsigned WgtW   = 10;
  localparam int unsigned SqW    = 2 * ColW;
  localparam int unsigned ProdW  = SqW + WgtW;
  localparam int unsigned TermW  = ProdW + 2;
  localparam int unsigned SumW   = 34;
  localparam int unsigned CoordW = 10;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [WgtW-1:0] RedWeightRst   = 10'd218;
  localparam logic [WgtW-1:0] GreenWeightRst = 10'd256;
  localparam logic [WgtW-1:0] BlueWeightRst  = 10'd154;
  localparam logic [SumW-1:0] SumMax         = {SumW{1'b1}};

  typedef enum logic [CfgAddrW-1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                valid;
    logic [CfgAddrW-1:0] addr;
    logic [WgtW-1:0]     data;
  } cfg_wr_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic [TermW-1:0]  term;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [WordW-1:0]  pixel;
    logic              hood_end;
    logic              search_end;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } front_out_t;

endpackage

// ===== design/nsbm_front.sv =====
module nsbm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nsbm_pkg::cfg_wr_t             cfg_i,
  input  logic                          in_valid_i,
  input  logic [nsbm_pkg::ColW-1:0]     cand_red_i,
  input  logic [nsbm_pkg::ColW-1:0]     cand_green_i,
  input  logic [nsbm_pkg::ColW-1:0]     cand_blue_i,
  input  logic [nsbm_pkg::ColW-1:0]     targ_red_i,
  input  logic [nsbm_pkg::ColW-1:0]     targ_green_i,
  input  logic [nsbm_pkg::ColW-1:0]     targ_blue_i,
  input  logic [nsbm_pkg::CoordW-1:0]   cand_x_i,
  input  logic [nsbm_pkg::CoordW-1:0]   cand_y_i,
  input  logic [nsbm_pkg::WordW-1:0]    cand_pixel_i,
  input  logic                          hood_end_i,
  input  logic                          search_end_i,
  output nsbm_pkg::front_out_t          out_o,
  output logic [1:0]                    inflight_o
);

  logic [nsbm_pkg::WgtW-1:0] weight_q [3];
  logic [nsbm_pkg::WgtW-1:0] weight_d [3];

  logic [nsbm_pkg::ColW-1:0] cand [3];
  logic [nsbm_pkg::ColW-1:0] targ [3];
  logic [nsbm_pkg::ColW-1:0] diff [3];

  logic                       s1_valid_q;
  logic [nsbm_pkg::SqW-1:0]   s1_sq_q [3];
  logic [nsbm_pkg::SqW-1:0]   s1_sq_d [3];
  nsbm_pkg::entry_t           s1_meta_q;

  logic                       s2_valid_q;
  logic [nsbm_pkg::ProdW-1:0] s2_prod_q [3];
  logic [nsbm_pkg::ProdW-1:0] s2_prod_d [3];
  nsbm_pkg::entry_t           s2_meta_q;

  nsbm_pkg::entry_t           in_meta;

  always_comb begin
    weight_d = weight_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        nsbm_pkg::CFG_RED:   weight_d[0] = cfg_i.data;
        nsbm_pkg::CFG_GREEN: weight_d[1] = cfg_i.data;
        nsbm_pkg::CFG_BLUE:  weight_d[2] = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q[0] <= nsbm_pkg::RedWeightRst;
      weight_q[1] <= nsbm_pkg::GreenWeightRst;
      weight_q[2] <= nsbm_pkg::BlueWeightRst;
    end else begin
      weight_q <= weight_d;
    end
  end

  assign cand[0] = cand_red_i;
  assign cand[1] = cand_green_i;
  assign cand[2] = cand_blue_i;
  assign targ[0] = targ_red_i;
  assign targ[1] = targ_green_i;
  assign targ[2] = targ_blue_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]    = (cand[c] >= targ[c]) ? (cand[c] - targ[c]) : (targ[c] - cand[c]);
      s1_sq_d[c] = nsbm_pkg::SqW'(diff[c]) * nsbm_pkg::SqW'(diff[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_prod_d[c] = nsbm_pkg::ProdW'(s1_sq_q[c]) * nsbm_pkg::ProdW'(weight_q[c]);
    end
  end

  always_comb begin
    in_meta            = '0;
    in_meta.x          = cand_x_i;
    in_meta.y          = cand_y_i;
    in_meta.pixel      = cand_pixel_i;
    in_meta.hood_end   = hood_end_i;
    in_meta.search_end = search_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sq_q   <= s1_sq_d;
    s1_meta_q <= in_meta;
    s2_prod_q <= s2_prod_d;
    s2_meta_q <= s1_meta_q;
  end

  always_comb begin
    out_o.valid      = s2_valid_q;
    out_o.entry      = s2_meta_q;
    out_o.entry.term = nsbm_pkg::TermW'(s2_prod_q[0]) + nsbm_pkg::TermW'(s2_prod_q[1])
                     + nsbm_pkg::TermW'(s2_prod_q[2]);
  end

  assign inflight_o = {1'b0, s1_valid_q} + {1'b0, s2_valid_q};

endmodule

// ===== design/nsbm_queue.sv =====
module nsbm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_valid_i,
  input  nsbm_pkg::entry_t               wr_data_i,
  output logic                           rd_valid_o,
  output nsbm_pkg::entry_t               rd_data_o,
  input  logic                           rd_ready_i,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  nsbm_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign do_wr = wr_valid_i;
  assign do_rd = rd_ready_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;

endmodule

// ===== design/nsbm_back.sv =====
module nsbm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  nsbm_pkg::entry_t              in_data_i,
  output logic                          in_ready_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [nsbm_pkg::CoordW-1:0]   best_x_o,
  output logic [nsbm_pkg::CoordW-1:0]   best_y_o,
  output logic [nsbm_pkg::WordW-1:0]    best_color_o,
  output logic [nsbm_pkg::SumW-1:0]     best_score_o
);

  logic [nsbm_pkg::SumW-1:0]   running_q, running_d;
  logic                        have_best_q, have_best_d;
  logic [nsbm_pkg::SumW-1:0]   best_sum_q, best_sum_d;
  logic [nsbm_pkg::CoordW-1:0] best_col_q, best_col_d;
  logic [nsbm_pkg::CoordW-1:0] best_row_q, best_row_d;
  logic [nsbm_pkg::WordW-1:0]  best_word_q, best_word_d;

  logic                        out_valid_q, out_valid_d;
  logic [nsbm_pkg::CoordW-1:0] out_x_q, out_x_d;
  logic [nsbm_pkg::CoordW-1:0] out_y_q, out_y_d;
  logic [nsbm_pkg::WordW-1:0]  out_word_q, out_word_d;
  logic [nsbm_pkg::SumW-1:0]   out_sum_q, out_sum_d;

  logic [nsbm_pkg::SumW:0]     raw_sum;
  logic [nsbm_pkg::SumW-1:0]   total;
  logic                        take, is_end, pop_ok, process;
  logic [nsbm_pkg::SumW-1:0]   nb_sum;
  logic [nsbm_pkg::CoordW-1:0] nb_col, nb_row;
  logic [nsbm_pkg::WordW-1:0]  nb_word;

  assign pop_ok  = pop && out_valid_q;
  assign is_end  = in_data_i.hood_end && in_data_i.search_end;
  // a search end needs the result slot free (or freeing this cycle)
  assign process = in_valid_i && (!is_end || !out_valid_q || pop_ok);
  assign in_ready_o = process;

  assign raw_sum = {1'b0, running_q} + (nsbm_pkg::SumW + 1)'(in_data_i.term);
  assign total   = raw_sum[nsbm_pkg::SumW] ? nsbm_pkg::SumMax : raw_sum[nsbm_pkg::SumW-1:0];
  assign take    = !have_best_q || (total < best_sum_q);

  assign nb_sum  = take ? total          : best_sum_q;
  assign nb_col  = take ? in_data_i.x     : best_col_q;
  assign nb_row  = take ? in_data_i.y     : best_row_q;
  assign nb_word = take ? in_data_i.pixel : best_word_q;

  always_comb begin
    running_d   = running_q;
    have_best_d = have_best_q;
    best_sum_d  = best_sum_q;
    best_col_d  = best_col_q;
    best_row_d  = best_row_q;
    best_word_d = best_word_q;
    out_valid_d = out_valid_q && !pop_ok;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_word_d  = out_word_q;
    out_sum_d   = out_sum_q;
    if (process) begin
      if (!in_data_i.hood_end) begin
        running_d = total;
      end else begin
        running_d = '0;
        if (in_data_i.search_end) begin
          out_valid_d = 1'b1;
          out_x_d     = nb_col;
          out_y_d     = nb_row;
          out_word_d  = nb_word;
          out_sum_d   = nb_sum;
          have_best_d = 1'b0;
        end else begin
          have_best_d = 1'b1;
          best_sum_d  = nb_sum;
          best_col_d  = nb_col;
          best_row_d  = nb_row;
          best_word_d = nb_word;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_sum_q  <= best_sum_d;
    best_col_q  <= best_col_d;
    best_row_q  <= best_row_d;
    best_word_q <= best_word_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_word_q  <= out_word_d;
    out_sum_q   <= out_sum_d;
  end

  assign empty        = !out_valid_q;
  assign best_x_o     = out_x_q;
  assign best_y_o     = out_y_q;
  assign best_color_o = out_word_q;
  assign best_score_o = out_sum_q;

endmodule

// ===== design/neighborhood_ssd_best_match.sv =====
// A search end passes s1, s2, the queue (held while a result is unpopped), the result regs.
// Throughput: one word per cycle while full is low; squares and weights run in a two-stage
// front pipe; the back's accumulate/compare loop takes one word per cycle off the queue.
// full rises only when the queue plus front pipe hold QUEUE_DEPTH words (result not popped).
// Reset (async, active low): weights to 218/256/154, search state and the queue cleared.
module neighborhood_ssd_best_match #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [nsbm_pkg::CfgAddrW-1:0]         cfg_addr_i,
  input  logic [nsbm_pkg::WgtW-1:0]             cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic [nsbm_pkg::ColW-1:0]             cand_red_i,
  input  logic [nsbm_pkg::ColW-1:0]             cand_green_i,
  input  logic [nsbm_pkg::ColW-1:0]             cand_blue_i,
  input  logic [nsbm_pkg::ColW-1:0]             targ_red_i,
  input  logic [nsbm_pkg::ColW-1:0]             targ_green_i,
  input  logic [nsbm_pkg::ColW-1:0]             targ_blue_i,
  input  logic [nsbm_pkg::CoordW-1:0]           cand_x_i,
  input  logic [nsbm_pkg::CoordW-1:0]           cand_y_i,
  input  logic [nsbm_pkg::WordW-1:0]            cand_pixel_i,
  input  logic                                  hood_end_i,
  input  logic                                  search_end_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [nsbm_pkg::CoordW-1:0]           best_x_o,
  output logic [nsbm_pkg::CoordW-1:0]           best_y_o,
  output logic [nsbm_pkg::WordW-1:0]            best_color_o,
  output logic [nsbm_pkg::SumW-1:0]             best_score_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  nsbm_pkg::cfg_wr_t    cfg_wr;
  nsbm_pkg::front_out_t front_out;
  logic [1:0]           inflight;
  logic                 push_ok;
  logic                 q_rd_valid, q_rd_ready;
  nsbm_pkg::entry_t     q_rd_data;
  logic [CntW-1:0]      q_count;
  logic [CntW:0]        committed;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.addr  = cfg_addr_i;
  assign cfg_wr.data  = cfg_data_i;

  // words in the front pipe already own a queue slot
  assign committed = (CntW + 1)'(q_count) + (CntW + 1)'(inflight);
  assign full      = (committed >= (CntW + 1)'(QUEUE_DEPTH));
  assign push_ok   = push && !full;

  nsbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .in_valid_i   (push_ok),
    .cand_red_i   (cand_red_i),
    .cand_green_i (cand_green_i),
    .cand_blue_i  (cand_blue_i),
    .targ_red_i   (targ_red_i),
    .targ_green_i (targ_green_i),
    .targ_blue_i  (targ_blue_i),
    .cand_x_i     (cand_x_i),
    .cand_y_i     (cand_y_i),
    .cand_pixel_i (cand_pixel_i),
    .hood_end_i   (hood_end_i),
    .search_end_i (search_end_i),
    .out_o        (front_out),
    .inflight_o   (inflight)
  );

  nsbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_out.valid),
    .wr_data_i  (front_out.entry),
    .rd_valid_o (q_rd_valid),
    .rd_data_o  (q_rd_data),
    .rd_ready_i (q_rd_ready),
    .count_o    (q_count)
  );

  nsbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_rd_valid),
    .in_data_i    (q_rd_data),
    .in_ready_o   (q_rd_ready),
    .empty        (empty),
    .pop          (pop),
    .best_x_o     (best_x_o),
    .best_y_o     (best_y_o),
    .best_color_o (best_color_o),
    .best_score_o (best_score_o)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_out.valid |-> (q_count < CntW'(QUEUE_DEPTH)) || q_rd_ready)
    else $error("queue written while full");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed <= (CntW + 1)'(QUEUE_DEPTH))
    else $error("more words committed than queue slots");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(q_rd_valid && q_rd_ready && q_rd_data.hood_end
                           && q_rd_data.search_end))
    else $error("result appeared without a search end word");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import nsbm_pkg::*;

  localparam logic [CfgAddrW-1:0] CfgSpare = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef enum int unsigned {PIX_ANY, PIX_NEAR, PIX_LOUD} pix_mode_e;

  typedef struct packed {
    logic [ColW-1:0]   cand_red;
    logic [ColW-1:0]   cand_green;
    logic [ColW-1:0]   cand_blue;
    logic [ColW-1:0]   targ_red;
    logic [ColW-1:0]   targ_green;
    logic [ColW-1:0]   targ_blue;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [WordW-1:0]  pixel;
    logic              hood_end;
    logic              search_end;
  } pair_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [WordW-1:0]  color;
    logic [SumW-1:0]   score;
  } match_t;

  class match_scoreboard;
    logic [WgtW-1:0]   red_w, green_w, blue_w;
    longint unsigned   run_sum, best_sum;
    logic [CoordW-1:0] best_col, best_row;
    logic [WordW-1:0]  best_word;
    bit                have_best;
    match_t            expected[$];
    int unsigned       errors;

    function new();
      red_w = RedWeightRst;
      green_w = GreenWeightRst;
      blue_w = BlueWeightRst;
      errors = 0;
      clear_search();
    endfunction

    function void clear_search();
      run_sum = 0;
      best_sum = 0;
      best_col = '0;
      best_row = '0;
      best_word = '0;
      have_best = 1'b0;
    endfunction

    function void set_weight(logic [CfgAddrW-1:0] idx, logic [WgtW-1:0] val);
      case (idx)
        CFG_RED: red_w = val;
        CFG_GREEN: green_w = val;
        CFG_BLUE: blue_w = val;
        default: ;
      endcase
    endfunction

    function longint unsigned weighted_sq(logic [ColW-1:0] a, logic [ColW-1:0] b,
                                          logic [WgtW-1:0] w);
      longint unsigned d;
      d = (a >= b) ? a - b : b - a;
      return d * d * w;
    endfunction

    function void note_pixel(pair_t p);
      longint unsigned total;
      total = run_sum + weighted_sq(p.cand_red, p.targ_red, red_w)
            + weighted_sq(p.cand_green, p.targ_green, green_w)
            + weighted_sq(p.cand_blue, p.targ_blue, blue_w);
      if (total > SumMax) total = SumMax;
      if (!p.hood_end) begin
        run_sum = total;
        return;
      end
      if (!have_best || total < best_sum) begin
        best_sum = total;
        best_col = p.x;
        best_row = p.y;
        best_word = p.pixel;
        have_best = 1'b1;
      end
      run_sum = 0;
      if (p.search_end) begin
        expected.push_back('{best_col, best_row, best_word, SumW'(best_sum)});
        clear_search();
      end
    endfunction

    function void check_match(match_t got);
      match_t want;
      if (expected.size() == 0) begin
        $error("result word with nothing outstanding: x %0d y %0d score %0d",
               got.x, got.y, got.score);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.x !== want.x) begin
        $error("best_x: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("best_y: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.color !== want.color) begin
        $error("best_color: expected %08h, got %08h", want.color, got.color);
        errors++;
      end
      if (got.score !== want.score) begin
        $error("best_score: expected %0d, got %0d", want.score, got.score);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [WgtW-1:0]     cfg_data_i;
  logic                push;
  logic                full;
  logic [ColW-1:0]     cand_red_i, cand_green_i, cand_blue_i;
  logic [ColW-1:0]     targ_red_i, targ_green_i, targ_blue_i;
  logic [CoordW-1:0]   cand_x_i, cand_y_i;
  logic [WordW-1:0]    cand_pixel_i;
  logic                hood_end_i, search_end_i;
  logic                empty;
  logic                pop;
  logic [CoordW-1:0]   best_x_o, best_y_o;
  logic [WordW-1:0]    best_color_o;
  logic [SumW-1:0]     best_score_o;

  match_scoreboard sb;
  bit              quiet;
  int unsigned     n_sent;
  int unsigned     stall_count;

  neighborhood_ssd_best_match i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (push && !full) || (pop && !empty) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count <= 0;
    end else if (stall_count == StallLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    match_t seen;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        seen = '{best_x_o, best_y_o, best_color_o, best_score_o};
        sb.check_match(seen);
      end
      pop <= quiet || $urandom_range(0, 99) >= 12;
    end
  end

  function automatic pair_t grey_pair(input logic [ColW-1:0] c, input logic [ColW-1:0] t,
                                      input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                      input logic [WordW-1:0] pix, input logic he,
                                      input logic se);
    return '{c, c, c, t, t, t, x, y, pix, he, se};
  endfunction

  function automatic pair_t random_pair(input pix_mode_e mode);
    logic [127:0] bits;
    pair_t        p;
    bits = {$urandom, $urandom, $urandom, $urandom};
    p = bits[$bits(pair_t)-1:0];
    if (mode == PIX_NEAR) begin
      p.targ_red = $urandom_range(0, 1) ? p.cand_red : p.cand_red ^ ColW'($urandom_range(0, 3));
      p.targ_green = $urandom_range(0, 1) ? p.cand_green
                                          : p.cand_green ^ ColW'($urandom_range(0, 3));
      p.targ_blue = $urandom_range(0, 1) ? p.cand_blue
                                         : p.cand_blue ^ ColW'($urandom_range(0, 3));
    end else if (mode == PIX_LOUD) begin
      p.cand_red = {ColW{1'($urandom_range(0, 1))}};
      p.cand_green = {ColW{1'($urandom_range(0, 1))}};
      p.cand_blue = {ColW{1'($urandom_range(0, 1))}};
      p.targ_red = ~p.cand_red;
      p.targ_green = ~p.cand_green;
      p.targ_blue = ~p.cand_blue;
    end
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cand_red_i <= p.cand_red;
    cand_green_i <= p.cand_green;
    cand_blue_i <= p.cand_blue;
    targ_red_i <= p.targ_red;
    targ_green_i <= p.targ_green;
    targ_blue_i <= p.targ_blue;
    cand_x_i <= p.x;
    cand_y_i <= p.y;
    cand_pixel_i <= p.pixel;
    hood_end_i <= p.hood_end;
    search_end_i <= p.search_end;
    do @(posedge clk_i); while (full);
    sb.note_pixel(p);
    n_sent++;
  endtask

  // stray search_end bits on inner words must be ignored
  task automatic send_hood(input int unsigned len, input pix_mode_e mode, input bit ends);
    pair_t p;
    for (int unsigned i = 0; i < len; i++) begin
      p = random_pair(mode);
      p.hood_end = (i == len - 1);
      p.search_end = p.hood_end ? ends : ($urandom_range(0, 5) == 0);
      send_pair(p);
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop;
    int unsigned n_cand;
    int unsigned max_len;
    pix_mode_e   mode;
    stop = n_sent + n;
    while (n_sent < stop) begin
      n_cand = $urandom_range(1, 6);
      max_len = ($urandom_range(0, 19) == 0) ? 40 : 8;
      mode = ($urandom_range(0, 2) == 0) ? PIX_NEAR : PIX_ANY;
      for (int unsigned c = 0; c < n_cand; c++) begin
        send_hood($urandom_range(1, max_len), mode, c == n_cand - 1);
      end
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [WgtW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_weight(idx, val);
  endtask

  task automatic load_weights(input logic [WgtW-1:0] r, input logic [WgtW-1:0] g,
                              input logic [WgtW-1:0] b, input logic [WgtW-1:0] junk);
    write_reg(CfgSpare, junk);
    write_reg(CFG_RED, r);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_BLUE, b);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    pair_t p;
    sb = new();
    quiet = 1'b0;
    n_sent = 0;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_addr_i <= '0;
    cfg_data_i <= '0;
    push <= 1'b0;
    cand_red_i <= '0;
    cand_green_i <= '0;
    cand_blue_i <= '0;
    targ_red_i <= '0;
    targ_green_i <= '0;
    targ_blue_i <= '0;
    cand_x_i <= '0;
    cand_y_i <= '0;
    cand_pixel_i <= '0;
    hood_end_i <= 1'b0;
    search_end_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(grey_pair(8'd0, 8'd0, 10'd0, 10'd0, 32'h0, 1'b1, 1'b1));
    send_pair(grey_pair(8'd255, 8'd0, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_pair(grey_pair(8'd0, 8'd255, 10'd512, 10'd1, 32'hA5A5_5A5A, 1'b1, 1'b1));
    // lone search_end, tie kept, strictly smaller replaces, larger ignored
    send_pair(grey_pair(8'd10, 8'd20, 10'd700, 10'd701, 32'h1111_1111, 1'b0, 1'b1));
    send_pair(grey_pair(8'd10, 8'd20, 10'd3, 10'd4, 32'h2222_2222, 1'b1, 1'b0));
    send_pair(grey_pair(8'd0, 8'd10, 10'd800, 10'd801, 32'h3333_3333, 1'b0, 1'b0));
    send_pair(grey_pair(8'd40, 8'd30, 10'd9, 10'd9, 32'h4444_4444, 1'b1, 1'b0));
    send_pair(grey_pair(8'd5, 8'd6, 10'd11, 10'd12, 32'h5555_5555, 1'b1, 1'b0));
    send_pair(grey_pair(8'd100, 8'd90, 10'd13, 10'd14, 32'h6666_6666, 1'b1, 1'b1));
    for (int i = 0; i < 4; i++) begin
      p = random_pair(PIX_ANY);
      p.hood_end = 1'b1;
      p.search_end = 1'b1;
      send_pair(p);
    end
    random_phase(240);
    settle();

    load_weights('0, '0, '0, '1);
    random_phase(200);
    settle();

    // saturated scores tie, then a small score beats saturation
    load_weights('1, '1, '1, '0);
    send_hood(95, PIX_LOUD, 1'b0);
    send_hood(95, PIX_LOUD, 1'b1);
    send_hood(95, PIX_LOUD, 1'b0);
    send_hood(1, PIX_NEAR, 1'b1);
    random_phase(200);
    settle();

    quiet = 1'b1;
    load_weights(WgtW'($urandom_range(0, 1023)), WgtW'($urandom_range(0, 1023)),
                 WgtW'($urandom_range(0, 1023)), WgtW'($urandom_range(0, 1023)));
    random_phase(300);
    settle();
    quiet = 1'b0;

    load_weights('1, '0, WgtW'($urandom_range(0, 1023)), WgtW'($urandom_range(0, 1023)));
    random_phase(250);
    settle();

    load_weights(RedWeightRst, GreenWeightRst, BlueWeightRst, '1);
    random_phase(250);
    settle();

    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
